// ===== sv/iee_pkg.sv =====
package iee_pkg;

	localparam int DATA_W = 32;

	// token kinds
	localparam logic [2:0] K_NUM   = 3'd0;
	localparam logic [2:0] K_OP    = 3'd1;
	localparam logic [2:0] K_OPEN  = 3'd2;
	localparam logic [2:0] K_CLOSE = 3'd3;
	localparam logic [2:0] K_END   = 3'd4;

	// operator stack entries
	localparam logic [2:0] OPR_ADD   = 3'd0;
	localparam logic [2:0] OPR_SUB   = 3'd1;
	localparam logic [2:0] OPR_MUL   = 3'd2;
	localparam logic [2:0] OPR_DIV   = 3'd3;
	localparam logic [2:0] OPR_PAREN = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;
	localparam logic [1:0] ST_DIV0 = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EVAL,
		S_MUL,
		S_DIV,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		WB_ADDSUB,
		WB_MUL,
		WB_DIV
	} wb_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       load_tok;
		logic       push_num;
		logic       push_opr;
		logic       opr_paren;
		logic       pop_opr;
		logic       set_err;
		logic [1:0] err_code;
		logic       wb;
		wb_sel_t    wb_sel;
		logic       mul_cap;
		logic       div_start;
		logic       emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] op;
		logic       err_set;
		logic       opr_empty;
		logic       opr_full;
		logic       opd_full;
		logic       opd_one;
		logic       opd_lt2;
		logic [2:0] top_code;
		logic       b_zero;
		logic       div_done;
		logic       out_busy;
	} stat_t;

endpackage

// ===== sv/iee_ram.sv =====
module iee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== sv/iee_div.sv =====
module iee_div import iee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int SW = $clog2(DATA_W);

	logic [SW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic              neg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	// control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + SW'(1);
				if (cnt_q == SW'(DATA_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division on magnitudes; the remainder stays below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
			dsr_q <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
			rem_q <= '0;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (run_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;

endmodule

// ===== sv/iee_dp.sv =====
module iee_dp import iee_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        kind,
	input  logic [1:0]        op_code,
	input  logic [DATA_W-1:0] number_value,
	input  cmd_t              cmd,
	output stat_t             st,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] result_value,
	output logic [1:0]        status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	logic [2:0]        kind_q;
	logic [1:0]        op_q;
	logic [DATA_W-1:0] num_q;
	logic [CW-1:0]     opr_cnt_q;
	logic [CW-1:0]     opd_cnt_q;
	logic [1:0]        err_q;
	logic [DATA_W-1:0] mul_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] result_q;
	logic [1:0]        status_q;

	logic [CW-1:0]     opr_top;
	logic [CW-1:0]     opd_b;
	logic [CW-1:0]     opd_a;
	logic [2:0]        opr_rd;
	logic [2:0]        opr_alu;
	logic [2:0]        opr_wdata;
	logic [DATA_W-1:0] a_rd;
	logic [DATA_W-1:0] b_rd;
	logic              opd_we;
	logic [AW-1:0]     opd_waddr;
	logic [DATA_W-1:0] opd_wdata;
	logic [DATA_W-1:0] wb_val;
	logic [DATA_W-1:0] div_q;
	logic              div_done;

	assign opr_top = opr_cnt_q - CW'(1);
	assign opd_b   = opd_cnt_q - CW'(1);
	assign opd_a   = opd_cnt_q - CW'(2);

	// operator stack: port a feeds the controller, port b the adder select
	assign opr_wdata = cmd.opr_paren ? OPR_PAREN : {1'b0, op_q};

	iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_opr_ram (
		.clk     (clk),
		.we      (cmd.push_opr),
		.waddr   (opr_cnt_q[AW-1:0]),
		.wdata   (opr_wdata),
		.raddr_a (opr_top[AW-1:0]),
		.rdata_a (opr_rd),
		.raddr_b (opr_top[AW-1:0]),
		.rdata_b (opr_alu)
	);

	// operand stack: top two entries read every cycle
	always_comb begin
		unique case (cmd.wb_sel)
			WB_MUL:  wb_val = mul_q;
			WB_DIV:  wb_val = div_q;
			default: wb_val = (opr_alu == OPR_SUB) ? (a_rd - b_rd) : (a_rd + b_rd);
		endcase
	end

	assign opd_we    = cmd.push_num | cmd.wb;
	assign opd_waddr = cmd.wb ? opd_a[AW-1:0] : opd_cnt_q[AW-1:0];
	assign opd_wdata = cmd.wb ? wb_val : num_q;

	iee_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_opd_ram (
		.clk     (clk),
		.we      (opd_we),
		.waddr   (opd_waddr),
		.wdata   (opd_wdata),
		.raddr_a (opd_a[AW-1:0]),
		.rdata_a (a_rd),
		.raddr_b (opd_b[AW-1:0]),
		.rdata_b (b_rd)
	);

	iee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (a_rd),
		.divisor  (b_rd),
		.done     (div_done),
		.quotient (div_q)
	);

	// token, product and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			kind_q <= kind;
			op_q   <= op_code;
			num_q  <= number_value;
		end
		if (cmd.mul_cap) begin
			mul_q <= a_rd * b_rd;
		end
		if (cmd.emit) begin
			status_q <= err_q;
			result_q <= (err_q == ST_OK) ? b_rd : '0;
		end
	end

	// stack counts, sticky error, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opr_cnt_q   <= '0;
			opd_cnt_q   <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				opr_cnt_q <= '0;
				opd_cnt_q <= '0;
				err_q     <= ST_OK;
			end else begin
				if (cmd.push_num) begin
					opd_cnt_q <= opd_cnt_q + CW'(1);
				end else if (cmd.wb) begin
					opd_cnt_q <= opd_b;
				end
				if (cmd.push_opr) begin
					opr_cnt_q <= opr_cnt_q + CW'(1);
				end else if (cmd.pop_opr || cmd.wb) begin
					opr_cnt_q <= opr_top;
				end
				if (cmd.set_err && err_q == ST_OK) begin
					err_q <= cmd.err_code;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status towards the controller
	always_comb begin
		st.kind      = kind_q;
		st.op        = op_q;
		st.err_set   = (err_q != ST_OK);
		st.opr_empty = (opr_cnt_q == '0);
		st.opr_full  = (opr_cnt_q == FULL);
		st.opd_full  = (opd_cnt_q == FULL);
		st.opd_one   = (opd_cnt_q == CW'(1));
		st.opd_lt2   = (opd_cnt_q < CW'(2));
		st.top_code  = opr_rd;
		st.b_zero    = (b_rd == '0);
		st.div_done  = div_done;
		st.out_busy  = out_valid_q & ~out_ready;
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;

endmodule

// ===== sv/iee_ctrl.sv =====
module iee_ctrl import iee_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   reduce;
	logic   prec_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// incoming operator yields to a stacked one of equal or higher precedence
	assign prec_ok = ~st.op[1] | st.top_code[1];

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.wb_sel = WB_ADDSUB;
		in_ready = 1'b0;
		reduce   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_tok = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_IDLE;
				if (st.kind == K_END) begin
					state_d = S_READ;
				end else if (!st.err_set) begin
					priority if (st.kind == K_NUM) begin
						if (st.opd_full) begin
							cmd.set_err  = 1'b1;
							cmd.err_code = ST_OVF;
						end else begin
							cmd.push_num = 1'b1;
						end
					end else if (st.kind == K_OPEN) begin
						if (st.opr_full) begin
							cmd.set_err  = 1'b1;
							cmd.err_code = ST_OVF;
						end else begin
							cmd.push_opr  = 1'b1;
							cmd.opr_paren = 1'b1;
						end
					end else if (st.kind == K_OP || st.kind == K_CLOSE) begin
						state_d = S_READ;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_IDLE;
				priority if (st.kind == K_END) begin
					state_d = S_EMIT;
					if (!st.err_set) begin
						if (st.opr_empty) begin
							if (!st.opd_one) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ST_BAD;
							end
						end else if (st.top_code == OPR_PAREN) begin
							cmd.set_err  = 1'b1;
							cmd.err_code = ST_BAD;
						end else begin
							reduce = 1'b1;
						end
					end
				end else if (st.kind == K_OP) begin
					if (!st.opr_empty && st.top_code != OPR_PAREN && prec_ok) begin
						reduce = 1'b1;
					end else if (st.opr_full) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_OVF;
					end else begin
						cmd.push_opr = 1'b1;
					end
				end else begin
					if (st.opr_empty) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_BAD;
					end else if (st.top_code == OPR_PAREN) begin
						cmd.pop_opr = 1'b1;
					end else begin
						reduce = 1'b1;
					end
				end
				// one reduction of the top operator
				if (reduce) begin
					if (st.opd_lt2) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_BAD;
					end else if (st.top_code == OPR_DIV) begin
						if (st.b_zero) begin
							cmd.set_err  = 1'b1;
							cmd.err_code = ST_DIV0;
						end else begin
							cmd.div_start = 1'b1;
							state_d = S_DIV;
						end
					end else if (st.top_code == OPR_MUL) begin
						cmd.mul_cap = 1'b1;
						state_d = S_MUL;
					end else begin
						cmd.wb = 1'b1;
						state_d = S_READ;
					end
				end
			end
			S_MUL: begin
				cmd.wb     = 1'b1;
				cmd.wb_sel = WB_MUL;
				state_d    = S_READ;
			end
			S_DIV: begin
				if (st.div_done) begin
					cmd.wb     = 1'b1;
					cmd.wb_sel = WB_DIV;
					state_d    = S_READ;
				end
			end
			S_EMIT: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/infix_expression_evaluator.sv =====
// Infix integer expression evaluator, one token per input request.
// Input channel: in_valid/in_ready carry kind, op_code and number_value.
// Output channel: out_valid/out_ready carry result_value and status; one
// result leaves for each end token, none for any other token.
// Flow: the controller takes a token in its idle state and decodes it in
// its check state, which pushes numbers and open parentheses. Operators,
// close parentheses and end pass a read state (registered stack memory
// read) and an evaluate state per stack inspection; add and subtract write
// back from evaluate, multiply passes a mul state, and divide waits in a
// div state (one quotient bit a cycle). End finally loads the output register.
// Reset clears both stack pointers and the error; stack contents are not
// cleared. The output register holds a result until it is taken; a new
// token is accepted meanwhile, and only a following end token waits while
// the previous result is still stalled.
module infix_expression_evaluator import iee_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	input  logic [1:0]        op_code,
	input  logic signed [DATA_W-1:0] number_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [DATA_W-1:0] result_value,
	output logic [1:0]        status
);

	cmd_t  cmd;
	stat_t st;

	iee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	iee_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (kind),
		.op_code      (op_code),
		.number_value (number_value),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status)
	);

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_value == '0)
		else $error("failed expression gives a nonzero value");

	a_rise_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.emit))
		else $error("result appeared without an emit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && !out_ready))
		else $error("pending result overwritten");

	a_wb_operands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> !st.opd_lt2 && !st.opr_empty)
		else $error("reduction with too few stack entries");
`endif

endmodule
